@@ hdl/tvt_pkg.sv @@
package tvt_pkg;

	// Item commands
	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// Envelope phases
	typedef enum logic [1:0] {
		ADSR_ATTACK  = 2'd0,
		ADSR_DECAY   = 2'd1,
		ADSR_SUSTAIN = 2'd2,
		ADSR_RELEASE = 2'd3
	} adsr_t;

	localparam int unsigned NUM_VOICES = 3;
	localparam int unsigned NUM_REGS   = 32;
	localparam int unsigned VOICE_STRIDE = 7;
	localparam int unsigned OFF_CTRL   = 4;

	localparam logic [4:0] ADDR_POT_X   = 5'h19;
	localparam logic [4:0] ADDR_POT_Y   = 5'h1A;
	localparam logic [4:0] ADDR_OSC3    = 5'h1B;
	localparam logic [4:0] ADDR_ENV3    = 5'h1C;
	localparam logic [4:0] ADDR_UNUSED0 = 5'h1D;
	localparam logic [4:0] ADDR_UNUSED1 = 5'h1E;
	localparam logic [4:0] ADDR_UNUSED2 = 5'h1F;

	localparam logic [22:0] NOISE_SEED = 23'h7FFFFF;

	// Control into one envelope unit
	typedef struct packed {
		logic step;
		logic gate_on;
		logic gate_off;
		logic std;
	} env_ctl_t;

	typedef logic [16:0] rate_tab_t [2][16];

	localparam rate_tab_t ATK_TAB = '{
		'{17'd8, 17'd31, 17'd62, 17'd93, 17'd147, 17'd216, 17'd263, 17'd309,
		  17'd386, 17'd966, 17'd1932, 17'd3091, 17'd3864, 17'd11592, 17'd19320, 17'd30911},
		'{17'd8, 17'd32, 17'd64, 17'd97, 17'd153, 17'd224, 17'd273, 17'd321,
		  17'd401, 17'd1003, 17'd2005, 17'd3209, 17'd4011, 17'd12033, 17'd20055, 17'd32087}
	};

	localparam rate_tab_t DEC_TAB = '{
		'{17'd23, 17'd93, 17'd185, 17'd278, 17'd440, 17'd649, 17'd788, 17'd927,
		  17'd1159, 17'd2897, 17'd5794, 17'd9271, 17'd11592, 17'd34775, 17'd57959, 17'd92734},
		'{17'd24, 17'd97, 17'd192, 17'd289, 17'd457, 17'd674, 17'd818, 17'd962,
		  17'd1203, 17'd3007, 17'd6014, 17'd9624, 17'd12033, 17'd36098, 17'd60164, 17'd96262}
	};

	// Address of a voice register
	function automatic logic [4:0] voice_addr(input int v, input int off);
		voice_addr = 5'(VOICE_STRIDE * v + off);
	endfunction

	// Stretch a decay period at low levels (x30 as x32 - x2)
	function automatic logic [21:0] slow_period(input logic [16:0] d, input logic [7:0] lvl);
		logic [21:0] w;
		w = 22'(d);
		if (lvl >= 8'd93)      slow_period = w;
		else if (lvl >= 8'd54) slow_period = w << 1;
		else if (lvl >= 8'd26) slow_period = w << 2;
		else if (lvl >= 8'd14) slow_period = w << 3;
		else if (lvl >= 8'd6)  slow_period = w << 4;
		else                   slow_period = (w << 5) - (w << 1);
	endfunction

endpackage

@@ hdl/tvt_env.sv @@
module tvt_env (
	input  logic              clk,
	input  logic              arst_n,
	input  tvt_pkg::env_ctl_t ctl,
	input  logic [7:0]        ad,
	input  logic [7:0]        sr,
	output logic [7:0]        level,
	output logic [7:0]        level_next
);
	import tvt_pkg::*;

	adsr_t       state_q, state_d;
	logic [7:0]  level_q, level_d;
	logic [21:0] count_q, count_d;
	logic [21:0] count_inc;
	logic [21:0] period;
	logic [7:0]  sus;
	logic [7:0]  lvl_step;
	logic        hit;

	assign sus       = 8'({4'd0, sr[7:4]} * 8'd17);
	assign count_inc = count_q + 22'd1;

	// Pick the step period for the current phase
	always_comb begin
		unique case (state_q)
			ADSR_ATTACK: period = 22'(ATK_TAB[ctl.std][ad[7:4]]);
			ADSR_DECAY:  period = slow_period(DEC_TAB[ctl.std][ad[3:0]], level_q);
			ADSR_SUSTAIN: period = '0;
			ADSR_RELEASE: period = slow_period(DEC_TAB[ctl.std][sr[3:0]], level_q);
			default:     period = '0;
		endcase
	end

	assign hit = (count_inc >= period);

	// Next phase, level and count
	always_comb begin
		state_d  = state_q;
		level_d  = level_q;
		count_d  = count_q;
		lvl_step = level_q;
		if (ctl.gate_on) begin
			state_d = ADSR_ATTACK;
			count_d = '0;
		end else if (ctl.gate_off) begin
			state_d = ADSR_RELEASE;
		end else if (ctl.step) begin
			unique case (state_q)
				ADSR_ATTACK: begin
					count_d = hit ? '0 : count_inc;
					if (hit) begin
						lvl_step = (level_q != 8'd255) ? level_q + 8'd1 : level_q;
						level_d  = lvl_step;
						if (lvl_step == 8'd255) state_d = ADSR_DECAY;
					end
				end
				ADSR_DECAY: begin
					count_d = hit ? '0 : count_inc;
					if (hit) begin
						lvl_step = (level_q > sus) ? level_q - 8'd1 : level_q;
						level_d  = lvl_step;
						if (lvl_step <= sus) begin
							level_d = sus;
							state_d = ADSR_SUSTAIN;
						end
					end
				end
				ADSR_SUSTAIN: level_d = sus;
				ADSR_RELEASE: begin
					count_d = hit ? '0 : count_inc;
					if (hit && level_q != 8'd0) level_d = level_q - 8'd1;
				end
				default: state_d = state_q;
			endcase
		end
	end

	// Hold envelope state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ADSR_RELEASE;
			level_q <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			level_q <= level_d;
			count_q <= count_d;
		end
	end

	assign level      = level_q;
	assign level_next = level_d;

	a_sustain_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ADSR_SUSTAIN && ctl.step && !ctl.gate_on && !ctl.gate_off)
		|=> level_q == $past(sus))
		else $error("sustain level not applied");

	a_gate_restart: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.gate_on |=> (state_q == ADSR_ATTACK && count_q == '0))
		else $error("gate rise did not restart attack");

	a_release_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ADSR_RELEASE && level_q == 8'd0 && !ctl.gate_on) |=> level_q == 8'd0)
		else $error("release went below zero");

endmodule

@@ hdl/three_voice_tone_envelope_generator_core.sv @@
// A transfer accepted into the input register waits there while the result side
// stalls; when it fires, its result is written into the output register.
// Throughput: one item per cycle while the result side does not stall; each
// item is done in one pass between the input register and the result register.
// Reset: arst_n clears registers, phases and envelopes, seeds noise to all ones,
// puts every envelope in release and sets wave_enable to 1.
module three_voice_tone_envelope_generator_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [1:0]        cmd,
	input  logic [4:0]        reg_addr,
	input  logic [7:0]        write_data,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [7:0]        read_data,
	output logic signed [8:0] wave_one,
	output logic signed [8:0] wave_two,
	output logic signed [8:0] wave_three,
	output logic [7:0]        env_one,
	output logic [7:0]        env_two,
	output logic [7:0]        env_three,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic              cfg_data
);
	import tvt_pkg::*;

	// Input register
	logic       s1_valid_q;
	cmd_t       cmd_s1;
	logic [4:0] addr_s1;
	logic [7:0] data_s1;
	logic       advance, fire, accept;

	// Architectural state
	logic [7:0]        rf_q     [NUM_REGS];
	logic [23:0]       phase_q  [NUM_VOICES];
	logic [22:0]       noise_q  [NUM_VOICES];
	logic signed [8:0] held_q   [NUM_VOICES];
	logic [7:0]        osc3_q, env3_q;
	logic              std_q, wave_en_q;

	logic [7:0]        rf_d     [NUM_REGS];
	logic [23:0]       phase_d  [NUM_VOICES];
	logic [22:0]       noise_d  [NUM_VOICES];
	logic signed [8:0] held_d   [NUM_VOICES];
	logic [7:0]        osc3_d, env3_d;

	// Output register
	logic              result_valid_q;
	logic [7:0]        read_data_q;
	logic signed [8:0] wave_q   [NUM_VOICES];
	logic [7:0]        env_q    [NUM_VOICES];

	// Per-voice working values
	logic [24:0] ph_sum  [NUM_VOICES];
	logic        wrap    [NUM_VOICES];
	logic [23:0] ph_new  [NUM_VOICES];
	logic [23:0] tri_w   [NUM_VOICES];
	logic [11:0] pw      [NUM_VOICES];
	logic [7:0]  pulse_b [NUM_VOICES];
	logic [22:0] lfsr_n  [NUM_VOICES];
	logic [22:0] noise_v [NUM_VOICES];
	logic [7:0]  wbyte   [NUM_VOICES];
	logic [7:0]  ctrl    [NUM_VOICES];
	logic        is_tick;
	logic [7:0]  rd;

	env_ctl_t    env_ctl   [NUM_VOICES];
	logic [7:0]  env_lvl   [NUM_VOICES];
	logic [7:0]  env_nxt   [NUM_VOICES];

	// Handshake
	assign advance    = !result_valid_q || !result_stall;
	assign fire       = s1_valid_q && advance;
	assign item_stall = s1_valid_q && !advance;
	assign accept     = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;
	assign is_tick    = fire && (cmd_s1 == CMD_TICK);

	// Load the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd_t'(cmd);
			addr_s1 <= reg_addr;
			data_s1 <= write_data;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			std_q     <= 1'b0;
			wave_en_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == 1'b0) std_q     <= cfg_data;
			else                   wave_en_q <= cfg_data;
		end
	end

	// Advance the oscillators
	always_comb begin
		for (int i = 0; i < NUM_VOICES; i++) begin
			ctrl[i]   = rf_q[voice_addr(i, OFF_CTRL)];
			ph_sum[i] = {1'b0, phase_q[i]} +
				{9'd0, rf_q[voice_addr(i, 1)], rf_q[voice_addr(i, 0)]};
			wrap[i]   = !ctrl[i][3] && ph_sum[i][24];
			ph_new[i] = ctrl[i][3] ? phase_q[i] : ph_sum[i][23:0];
		end
		// hard sync from the previous voice in the ring
		for (int i = 0; i < NUM_VOICES; i++) begin
			if (ctrl[i][1] && wrap[(i + 2) % 3]) ph_new[i] = '0;
		end
	end

	// Form the waves
	always_comb begin
		for (int i = 0; i < NUM_VOICES; i++) begin
			tri_w[i] = ph_new[i];
			if (ctrl[i][2] && ph_new[(i + 2) % 3][23]) tri_w[i][23] = !tri_w[i][23];
			tri_w[i] = tri_w[i][23] ? {1'b0, ~tri_w[i][22:0]} : {1'b0, tri_w[i][22:0]};

			pw[i] = {rf_q[voice_addr(i, 3)][3:0], rf_q[voice_addr(i, 2)]};
			if (pw[i] == 12'd0)            pulse_b[i] = 8'd0;
			else if (pw[i] == 12'hFFF)     pulse_b[i] = 8'hFF;
			else if (ph_new[i] < {pw[i], 12'd0}) pulse_b[i] = 8'hFF;
			else                           pulse_b[i] = 8'd0;

			lfsr_n[i] = {noise_q[i][21:0], noise_q[i][22] ^ noise_q[i][17]};
			if (lfsr_n[i] == '0) lfsr_n[i] = 23'd1;
			noise_v[i] = noise_q[i];
			if (!phase_q[i][19] && ph_new[i][19]) noise_v[i] = lfsr_n[i];

			wbyte[i] = 8'hFF;
			if (ctrl[i][4]) wbyte[i] = wbyte[i] & tri_w[i][22:15];
			if (ctrl[i][5]) wbyte[i] = wbyte[i] & ph_new[i][23:16];
			if (ctrl[i][6]) wbyte[i] = wbyte[i] & pulse_b[i];
			if (ctrl[i][7]) wbyte[i] = wbyte[i] & {noise_v[i][20], noise_v[i][18],
				noise_v[i][14], noise_v[i][11], noise_v[i][9], noise_v[i][5],
				noise_v[i][2], noise_v[i][0]};
		end
	end

	// Next state for the item in the input register
	always_comb begin
		rf_d    = rf_q;
		phase_d = phase_q;
		noise_d = noise_q;
		held_d  = held_q;
		osc3_d  = osc3_q;
		env3_d  = env3_q;
		rd      = 8'd0;
		for (int i = 0; i < NUM_VOICES; i++) begin
			env_ctl[i].step     = is_tick;
			env_ctl[i].gate_on  = 1'b0;
			env_ctl[i].gate_off = 1'b0;
			env_ctl[i].std      = std_q;
		end
		if (fire) begin
			unique case (cmd_s1)
				CMD_WRITE: begin
					rf_d[addr_s1] = data_s1;
					for (int i = 0; i < NUM_VOICES; i++) begin
						if (addr_s1 == voice_addr(i, OFF_CTRL)) begin
							if (data_s1[3]) begin
								phase_d[i] = '0;
								held_d[i]  = '0;
							end
							env_ctl[i].gate_on  = !ctrl[i][0] && data_s1[0];
							env_ctl[i].gate_off = ctrl[i][0] && !data_s1[0];
						end
					end
				end
				CMD_READ: begin
					unique case (addr_s1)
						ADDR_POT_X, ADDR_POT_Y: rd = 8'hFF;
						ADDR_OSC3: rd = osc3_q;
						ADDR_ENV3: rd = env3_q;
						ADDR_UNUSED0, ADDR_UNUSED1, ADDR_UNUSED2: rd = 8'd0;
						default: rd = rf_q[addr_s1];
					endcase
				end
				CMD_TICK: begin
					for (int i = 0; i < NUM_VOICES; i++) begin
						phase_d[i] = ph_new[i];
						if (wave_en_q) begin
							if (ctrl[i][3] || ctrl[i][7:4] == 4'd0) begin
								held_d[i] = '0;
							end else begin
								held_d[i] = $signed({wbyte[i], 1'b1} ^ 9'h100);
								if (ctrl[i][7]) noise_d[i] = noise_v[i];
							end
						end
					end
					osc3_d = ph_new[2][23:16];
					env3_d = env_nxt[2];
				end
				CMD_NONE: rd = 8'd0;
				default:  rd = 8'd0;
			endcase
		end
	end

	// Envelope units
	for (genvar g = 0; g < NUM_VOICES; g++) begin : g_env
		tvt_env u_env (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (env_ctl[g]),
			.ad         (rf_q[voice_addr(g, 5)]),
			.sr         (rf_q[voice_addr(g, 6)]),
			.level      (env_lvl[g]),
			.level_next (env_nxt[g])
		);
	end

	// Hold architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_REGS; r++) rf_q[r] <= '0;
			for (int i = 0; i < NUM_VOICES; i++) begin
				phase_q[i] <= '0;
				noise_q[i] <= NOISE_SEED;
				held_q[i]  <= '0;
			end
			osc3_q <= '0;
			env3_q <= '0;
		end else begin
			rf_q    <= rf_d;
			phase_q <= phase_d;
			noise_q <= noise_d;
			held_q  <= held_d;
			osc3_q  <= osc3_d;
			env3_q  <= env3_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			read_data_q <= rd;
			for (int i = 0; i < NUM_VOICES; i++) begin
				wave_q[i] <= held_d[i];
				env_q[i]  <= env_nxt[i];
			end
		end
	end

	assign result_valid = result_valid_q;
	assign read_data    = read_data_q;
	assign wave_one     = wave_q[0];
	assign wave_two     = wave_q[1];
	assign wave_three   = wave_q[2];
	assign env_one      = env_q[0];
	assign env_two      = env_q[1];
	assign env_three    = env_q[2];

	a_stage_held: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !advance) |=> (s1_valid_q && $stable(cmd_s1) && $stable(addr_s1)))
		else $error("input stage lost a waiting item");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (s1_valid_q && result_valid_q))
		else $error("stall raised with free space");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && cmd_s1 != CMD_READ) |=> read_data_q == 8'd0)
		else $error("read data not zero for a non-read item");

	a_env_match: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> env_q[0] == env_lvl[0])
		else $error("envelope output does not match state");

endmodule

@@ verif/tvt_scoreboard.sv @@
`timescale 1ns / 1ps

module tvt_scoreboard
	import tvt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_stall,
	input  logic [1:0]        cmd,
	input  logic [4:0]        reg_addr,
	input  logic [7:0]        write_data,
	input  logic              result_valid,
	input  logic              result_stall,
	input  logic [7:0]        read_data,
	input  logic signed [8:0] wave_one,
	input  logic signed [8:0] wave_two,
	input  logic signed [8:0] wave_three,
	input  logic [7:0]        env_one,
	input  logic [7:0]        env_two,
	input  logic [7:0]        env_three,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic              cfg_index,
	input  logic              cfg_data,
	output int                errors,
	output int                pending
);

	typedef struct packed {
		logic [7:0]      rd;
		logic [2:0][8:0] wv;
		logic [2:0][7:0] ev;
	} voice_snapshot_t;

	voice_snapshot_t snap_q[$];

	logic        use_ntsc;
	logic        wave_on;
	logic [7:0]  regs [NUM_REGS];
	logic [23:0] phase [3];
	logic [22:0] lfsr [3];
	adsr_t       adsr [3];
	logic [7:0]  env [3];
	logic [21:0] rcount [3];
	logic [8:0]  held [3];
	logic [7:0]  osc3_rb;
	logic [7:0]  env3_rb;

	assign pending = snap_q.size();

	function automatic int unsigned slow_mult(logic [7:0] e);
		if (e >= 8'd93) return 1;
		if (e >= 8'd54) return 2;
		if (e >= 8'd26) return 4;
		if (e >= 8'd14) return 8;
		if (e >= 8'd6) return 16;
		return 30;
	endfunction

	function automatic void clear_model();
		use_ntsc = 1'b0;
		wave_on = 1'b1;
		for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
		for (int i = 0; i < 3; i++) begin
			phase[i] = '0;
			lfsr[i] = NOISE_SEED;
			adsr[i] = ADSR_RELEASE;
			env[i] = '0;
			rcount[i] = '0;
			held[i] = '0;
		end
		osc3_rb = '0;
		env3_rb = '0;
		snap_q.delete();
	endfunction

	function automatic void reg_write(logic [4:0] a, logic [7:0] d);
		logic [7:0] old;
		int v;
		old = regs[a];
		regs[a] = d;
		// control bytes: test clears the voice, gate edges move the envelope
		if (a <= 5'd20 && (a % VOICE_STRIDE) == OFF_CTRL) begin
			v = a / VOICE_STRIDE;
			if (d[3]) begin
				phase[v] = '0;
				held[v] = '0;
			end
			if (!old[0] && d[0]) begin
				adsr[v] = ADSR_ATTACK;
				rcount[v] = '0;
			end else if (old[0] && !d[0]) begin
				adsr[v] = ADSR_RELEASE;
			end
		end
	endfunction

	function automatic logic [7:0] reg_read(logic [4:0] a);
		case (a)
			ADDR_POT_X, ADDR_POT_Y: return 8'hFF;
			ADDR_OSC3: return osc3_rb;
			ADDR_ENV3: return env3_rb;
			ADDR_UNUSED0, ADDR_UNUSED1, ADDR_UNUSED2: return 8'h00;
			default: return regs[a];
		endcase
	endfunction

	function automatic logic [8:0] wave_level(int v, logic [23:0] prev, logic [23:0] src_ph);
		logic [7:0]  ctrl;
		logic [7:0]  c;
		logic [23:0] t;
		logic [11:0] pw;
		logic [22:0] r;
		int          lvl;
		ctrl = regs[VOICE_STRIDE * v + OFF_CTRL];
		c = 8'hFF;
		if (ctrl[3] || ctrl[7:4] == 4'h0) return '0;
		// triangle, ring modulation flips the fold bit
		if (ctrl[4]) begin
			t = phase[v];
			if (ctrl[2] && src_ph[23]) t[23] = ~t[23];
			c &= t[23] ? ~t[22:15] : t[22:15];
		end
		if (ctrl[5]) c &= phase[v][23:16];
		if (ctrl[6]) begin
			pw = {regs[VOICE_STRIDE * v + 3][3:0], regs[VOICE_STRIDE * v + 2]};
			if (pw == 12'h000) c = '0;
			else if (pw != 12'hFFF && phase[v] >= {pw, 12'h000}) c = '0;
		end
		// noise clocks on a rise of phase bit 19
		if (ctrl[7]) begin
			if (!prev[19] && phase[v][19]) begin
				r = {lfsr[v][21:0], lfsr[v][22] ^ lfsr[v][17]};
				if (r == '0) r = 23'd1;
				lfsr[v] = r;
			end
			r = lfsr[v];
			c &= {r[20], r[18], r[14], r[11], r[9], r[5], r[2], r[0]};
		end
		lvl = 2 * int'(c) - 255;
		return lvl[8:0];
	endfunction

	function automatic void env_advance(int v);
		logic [7:0]  ad;
		logic [7:0]  sr;
		logic [7:0]  sus;
		int unsigned period;
		int          s;
		ad = regs[VOICE_STRIDE * v + 5];
		sr = regs[VOICE_STRIDE * v + 6];
		sus = 8'(sr[7:4] * 17);
		s = use_ntsc ? 1 : 0;
		case (adsr[v])
			ADSR_ATTACK: begin
				period = 32'(ATK_TAB[s][ad[7:4]]);
				rcount[v] = rcount[v] + 22'd1;
				if (32'(rcount[v]) >= period) begin
					rcount[v] = '0;
					if (env[v] < 8'd255) env[v] = env[v] + 8'd1;
					if (env[v] == 8'd255) adsr[v] = ADSR_DECAY;
				end
			end
			ADSR_DECAY: begin
				period = 32'(DEC_TAB[s][ad[3:0]]) * slow_mult(env[v]);
				rcount[v] = rcount[v] + 22'd1;
				if (32'(rcount[v]) >= period) begin
					rcount[v] = '0;
					if (env[v] > sus) env[v] = env[v] - 8'd1;
					if (env[v] <= sus) begin
						env[v] = sus;
						adsr[v] = ADSR_SUSTAIN;
					end
				end
			end
			ADSR_SUSTAIN: env[v] = sus;
			default: begin
				period = 32'(DEC_TAB[s][sr[3:0]]) * slow_mult(env[v]);
				rcount[v] = rcount[v] + 22'd1;
				if (32'(rcount[v]) >= period) begin
					rcount[v] = '0;
					if (env[v] > 8'd0) env[v] = env[v] - 8'd1;
				end
			end
		endcase
	endfunction

	function automatic void tick();
		logic [23:0] prev [3];
		logic        wrapped [3];
		int          src [3];
		src = '{2, 0, 1};
		// advance phases unless test holds them
		for (int i = 0; i < 3; i++) begin
			prev[i] = phase[i];
			wrapped[i] = 1'b0;
			if (!regs[VOICE_STRIDE * i + OFF_CTRL][3]) begin
				phase[i] = phase[i] +
					{8'd0, regs[VOICE_STRIDE * i + 1], regs[VOICE_STRIDE * i]};
				wrapped[i] = phase[i] < prev[i];
			end
		end
		// hard sync from the source voice
		for (int i = 0; i < 3; i++)
			if (regs[VOICE_STRIDE * i + OFF_CTRL][1] && wrapped[src[i]]) phase[i] = '0;
		for (int i = 0; i < 3; i++) begin
			if (wave_on) held[i] = wave_level(i, prev[i], phase[src[i]]);
			env_advance(i);
		end
		osc3_rb = phase[2][23:16];
		env3_rb = env[2];
	endfunction

	function automatic voice_snapshot_t predict(cmd_t c, logic [4:0] a, logic [7:0] d);
		voice_snapshot_t s;
		s.rd = '0;
		case (c)
			CMD_WRITE: reg_write(a, d);
			CMD_READ: s.rd = reg_read(a);
			CMD_TICK: tick();
			default: ;
		endcase
		for (int i = 0; i < 3; i++) begin
			s.wv[i] = held[i];
			s.ev[i] = env[i];
		end
		return s;
	endfunction

	// Compare results first, then record the item taken at the same edge
	always @(posedge clk or negedge arst_n) begin
		voice_snapshot_t exp_s;
		voice_snapshot_t got;
		if (!arst_n) begin
			clear_model();
			errors <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				got.rd = read_data;
				got.wv = {wave_three, wave_two, wave_one};
				got.ev = {env_three, env_two, env_one};
				if (snap_q.size() == 0) begin
					$display("%0t: result transfer with nothing expected, rd=%0d", $time, read_data);
					errors <= errors + 1;
				end else begin
					exp_s = snap_q.pop_front();
					if (got !== exp_s) begin
						errors <= errors + 1;
						if (got.rd !== exp_s.rd)
							$display("%0t: read_data expected %0d actual %0d",
								$time, exp_s.rd, got.rd);
						for (int i = 0; i < 3; i++) begin
							if (got.wv[i] !== exp_s.wv[i])
								$display("%0t: wave[%0d] expected %0d actual %0d", $time, i,
									$signed(exp_s.wv[i]), $signed(got.wv[i]));
							if (got.ev[i] !== exp_s.ev[i])
								$display("%0t: env[%0d] expected %0d actual %0d", $time, i,
									exp_s.ev[i], got.ev[i]);
						end
					end
				end
			end
			if (item_valid && !item_stall)
				snap_q.push_back(predict(cmd_t'(cmd), reg_addr, write_data));
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == 1'b0) use_ntsc = cfg_data;
				else wave_on = cfg_data;
			end
		end
	end

endmodule

@@ verif/tb_three_voice_tone_envelope_generator_core.sv @@
`timescale 1ns / 1ps

module tb_three_voice_tone_envelope_generator_core;
	import tvt_pkg::*;

	localparam logic CFG_STD  = 1'b0;
	localparam logic CFG_WAVE = 1'b1;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	logic [1:0]        cmd;
	logic [4:0]        reg_addr;
	logic [7:0]        write_data;
	logic              result_valid;
	logic              result_stall;
	logic [7:0]        read_data;
	logic signed [8:0] wave_one;
	logic signed [8:0] wave_two;
	logic signed [8:0] wave_three;
	logic [7:0]        env_one;
	logic [7:0]        env_two;
	logic [7:0]        env_three;
	logic              cfg_valid;
	logic              cfg_ready;
	logic              cfg_index;
	logic              cfg_data;
	int                errors;
	int                pending;

	// stimulus shaping: no_idle is shared by sender and receiver, long_hold drives the receiver
	bit no_idle;
	bit long_hold;

	three_voice_tone_envelope_generator_core u_top (.*);

	tvt_scoreboard u_scoreboard (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Receiver: random stall before each result, plus one long hold-off
	initial begin
		int n;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				@(negedge clk) result_stall <= 1'b1;
				repeat (80) @(negedge clk);
				long_hold = 1'b0;
			end
			n = no_idle ? 0 : $urandom_range(0, 9);
			if (n > 0) begin
				@(negedge clk) result_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk) result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	task automatic send(input cmd_t c, input logic [4:0] a, input logic [7:0] d);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		cmd <= c;
		reg_addr <= a;
		write_data <= d;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk) item_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input logic idx, input logic val);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// Mostly ticks and voice programming with fast envelope rates
	task automatic random_item();
		int     k;
		int     v;
		int     off;
		logic [7:0] d;
		k = $urandom_range(0, 99);
		v = $urandom_range(0, 2);
		off = $urandom_range(0, 6);
		d = 8'($urandom);
		if (k < 60) begin
			send(CMD_TICK, 5'($urandom), d);
		end else if (k < 82) begin
			if (off == 5 || off == 6)
				d = {4'($urandom_range(0, 2)), 4'($urandom_range(0, 2))};
			if (off == OFF_CTRL && $urandom_range(0, 3) != 0) d[3] = 1'b0;
			if (off == 1 && $urandom_range(0, 1)) d = 8'($urandom_range(0, 15));
			send(CMD_WRITE, voice_addr(v, off), d);
		end else if (k < 87) begin
			send(CMD_WRITE, 5'($urandom), d);
		end else if (k < 97) begin
			send(CMD_READ, 5'($urandom), d);
		end else begin
			send(CMD_NONE, 5'($urandom), d);
		end
	endtask

	task automatic random_run(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
			random_item();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		cmd = CMD_NONE;
		reg_addr = '0;
		write_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_STD;
		cfg_data = 1'b0;
		no_idle = 1'b0;
		long_hold = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		cfg_write(CFG_STD, 1'b0);
		cfg_write(CFG_WAVE, 1'b1);

		// directed: field extremes, each waveform, special cases
		send(CMD_WRITE, voice_addr(0, 0), 8'hFF);
		send(CMD_WRITE, voice_addr(0, 1), 8'hFF);
		send(CMD_WRITE, voice_addr(0, 5), 8'h00);
		send(CMD_WRITE, voice_addr(0, 6), 8'hF0);
		send(CMD_WRITE, voice_addr(0, OFF_CTRL), 8'h11);
		send(CMD_TICK, 5'd0, 8'd0);
		send(CMD_WRITE, voice_addr(0, OFF_CTRL), 8'h21);
		send(CMD_TICK, 5'd31, 8'd255);
		send(CMD_WRITE, voice_addr(0, 2), 8'h00);
		send(CMD_WRITE, voice_addr(0, OFF_CTRL), 8'h41);
		send(CMD_TICK, 5'd0, 8'd0);
		send(CMD_WRITE, voice_addr(0, 3), 8'h0F);
		send(CMD_WRITE, voice_addr(0, 2), 8'hFF);
		send(CMD_TICK, 5'd0, 8'd0);
		send(CMD_WRITE, voice_addr(0, OFF_CTRL), 8'h81);
		send(CMD_TICK, 5'd0, 8'd0);
		send(CMD_WRITE, voice_addr(1, OFF_CTRL), 8'h16);
		send(CMD_WRITE, voice_addr(2, OFF_CTRL), 8'h08);
		send(CMD_TICK, 5'd0, 8'd0);
		send(CMD_WRITE, voice_addr(0, OFF_CTRL), 8'h00);
		send(CMD_READ, ADDR_POT_X, 8'd0);
		send(CMD_READ, ADDR_OSC3, 8'd0);
		send(CMD_READ, ADDR_ENV3, 8'd0);
		send(CMD_READ, ADDR_UNUSED2, 8'd0);
		send(CMD_NONE, 5'd31, 8'hFF);

		random_run(100);

		// wait out every result mid-phase, then keep going
		drain();
		random_run(20);

		cfg_write(CFG_STD, 1'b1);
		random_run(40);
		// long receiver hold while items keep coming
		long_hold = 1'b1;
		no_idle = 1'b1;
		for (int i = 0; i < 30; i++) send(CMD_TICK, 5'd0, 8'd0);
		no_idle = 1'b0;
		random_run(90);

		cfg_write(CFG_WAVE, 1'b0);
		random_run(80);

		cfg_write(CFG_STD, 1'b0);
		cfg_write(CFG_WAVE, 1'b1);
		random_run(65);

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
